>>> rtl/pcthr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcthr_pkg
// Types and constants shared by the power cap thread throttle unit.
// ----------------------------------------------------------------------------
package pcthr_pkg;

    localparam int PWR_W      = 20;   // power in 1/16 W
    localparam int CAP_W      = 11;   // thread cap
    localparam int WIN_W      = 5;    // averaging window
    localparam int AVG_FRAC   = 8;    // fraction bits of the average
    localparam int AVG_W      = PWR_W + AVG_FRAC;
    localparam int ACC_W      = AVG_W + WIN_W;
    localparam int HOLD_W     = 8;
    localparam int ACT_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = PWR_W;

    // quotient always fits the average width, so one step per average bit
    localparam int DIV_STEPS  = AVG_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOWER = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RAISE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOST       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FEWEST     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STOPPED    = 3'd5;

    localparam logic [PWR_W-1:0] RST_HIGH_LIMIT = 20'd3200;
    localparam logic [PWR_W-1:0] RST_LOW_LIMIT  = 20'd1600;
    localparam logic [CAP_W-1:0] RST_MOST       = 11'd16;
    localparam logic [CAP_W-1:0] RST_FEWEST     = 11'd1;
    localparam logic [WIN_W-1:0] RST_WINDOW     = 5'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_UPDATE
    } pcthr_state_t;

    typedef struct packed {
        logic [PWR_W-1:0] high_limit;
        logic [PWR_W-1:0] low_limit;
        logic [CAP_W-1:0] most;
        logic [CAP_W-1:0] fewest;
        logic [WIN_W-1:0] window;
        logic             stopped;
    } pcthr_cfg_t;

    typedef struct packed {
        logic load;      // capture sample
        logic mul;       // form accumulator, seed divider
        logic div_step;  // one restoring divide step
        logic commit;    // update state and result register
    } pcthr_cmd_t;

endpackage : pcthr_pkg
`default_nettype wire

>>> rtl/power_cap_thread_throttle_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// power_cap_thread_throttle_unit
// Power-capping thread limiter: running average and cap throttling per tick.
// ----------------------------------------------------------------------------
// Each input beat carries one power sample (1/16 W) and yields exactly one
// result beat: the thread cap, throttle flag, action code and the running
// average (8 fraction bits). A sample is captured, multiplied by (window-1),
// passed through a restoring divide by the window that retires one quotient
// bit per cycle, and then the decision is applied. A new sample is taken
// only after the previous one has been applied, and applying waits until
// the result register is free. The result sits in an output register, so
// the next sample is accepted while the previous result still waits.
// Configuration writes are always accepted; change registers only while no
// sample is in flight. Indices past the register list are ignored.
// ----------------------------------------------------------------------------
module power_cap_thread_throttle_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // sample channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [pcthr_pkg::PWR_W-1:0]       s_power_sample,
    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [pcthr_pkg::CAP_W-1:0]            m_cap_out,
    output logic                                   m_throttle_on,
    output logic [pcthr_pkg::ACT_W-1:0]            m_action,
    output logic [pcthr_pkg::AVG_W-1:0]            m_average_out,
    // register write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pcthr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pcthr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pcthr_pkg::*;

    pcthr_cfg_t cfg_reg;
    pcthr_cmd_t cmd;

    // register file; writes are registered, so never stall
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.high_limit <= RST_HIGH_LIMIT;
            cfg_reg.low_limit  <= RST_LOW_LIMIT;
            cfg_reg.most       <= RST_MOST;
            cfg_reg.fewest     <= RST_FEWEST;
            cfg_reg.window     <= RST_WINDOW;
            cfg_reg.stopped    <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_HIGH_LIMIT: cfg_reg.high_limit <= cfg_data;
                REG_LOW_LIMIT:  cfg_reg.low_limit  <= cfg_data;
                REG_MOST:       cfg_reg.most       <= cfg_data[CAP_W-1:0];
                REG_FEWEST:     cfg_reg.fewest     <= cfg_data[CAP_W-1:0];
                REG_WINDOW:     cfg_reg.window     <= cfg_data[WIN_W-1:0];
                REG_STOPPED:    cfg_reg.stopped    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer
    pcthr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // average, divider, decision and result register
    pcthr_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .s_power_sample (s_power_sample),
        .m_cap_out      (m_cap_out),
        .m_throttle_on  (m_throttle_on),
        .m_action       (m_action),
        .m_average_out  (m_average_out)
    );

`ifndef SYNTH
    // register file holds still between writes
    a_cfg_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(cfg_valid) |-> $stable(cfg_reg))
        else $error("register file changed without a write");
`endif

endmodule : power_cap_thread_throttle_unit
`default_nettype wire

>>> rtl/pcthr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcthr_ctrl
// Sequencer: accept, multiply, divide steps, update; owns result valid.
// ----------------------------------------------------------------------------
module pcthr_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output pcthr_pkg::pcthr_cmd_t  cmd
);
    import pcthr_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    pcthr_state_t      state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_DIV;
                cnt_next   = CNT_LAST;
            end
            ST_DIV: begin
                if (cnt_reg == '0) state_next = ST_UPDATE;
                else cnt_next = cnt_reg - 1'b1;
            end
            ST_UPDATE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_MUL:    cmd.mul      = 1'b1;
            ST_DIV:    cmd.div_step = 1'b1;
            ST_UPDATE: cmd.commit   = out_free;
            default: ;
        endcase
    end

    always_comb begin
        if (cmd.commit) out_valid_next = 1'b1;
        else if (m_ready) out_valid_next = 1'b0;
        else out_valid_next = out_valid_reg;
    end

    assign m_valid = out_valid_reg;

`ifndef SYNTH
    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!out_valid_reg || m_ready))
        else $error("result overwritten before taken");

    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid)
        else $error("commit did not raise m_valid");

    a_div_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |=> (state_reg == ST_DIV && cnt_reg == CNT_LAST))
        else $error("divider not seeded with full step count");

    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_MUL))
        else $error("accepted beat did not start work");
`endif

endmodule : pcthr_ctrl
`default_nettype wire

>>> rtl/pcthr_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcthr_dpath
// Average update (multiply, restoring divide) and cap decision logic.
// ----------------------------------------------------------------------------
module pcthr_dpath (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire pcthr_pkg::pcthr_cfg_t        cfg,
    input  wire pcthr_pkg::pcthr_cmd_t        cmd,
    input  wire logic [pcthr_pkg::PWR_W-1:0]  s_power_sample,
    output logic [pcthr_pkg::CAP_W-1:0]       m_cap_out,
    output logic                              m_throttle_on,
    output logic [pcthr_pkg::ACT_W-1:0]       m_action,
    output logic [pcthr_pkg::AVG_W-1:0]       m_average_out
);
    import pcthr_pkg::*;

    function automatic logic signed [HOLD_W-1:0] sat_dec(input logic signed [HOLD_W-1:0] h);
        sat_dec = (h == {1'b1, {(HOLD_W-1){1'b0}}}) ? h : h - 8'sd1;
    endfunction

    // architectural state
    logic [AVG_W-1:0]         avg_reg;
    logic signed [HOLD_W-1:0] hold_reg, hold_next;
    logic [CAP_W-1:0]         cap_reg, cap_next;
    logic                     flag_reg, flag_next;

    // working registers
    logic [PWR_W-1:0]         sample_reg;
    logic [WIN_W-1:0]         rem_reg, rem_next;
    logic [AVG_W-1:0]         quo_reg, quo_next;

    logic [CAP_W-1:0]         out_cap_reg;
    logic                     out_flag_reg;
    logic [ACT_W-1:0]         out_act_reg, act_next;
    logic [AVG_W-1:0]         out_avg_reg;

    logic [WIN_W-1:0]         w_eff, w_m1;
    logic [ACC_W-1:0]         acc;
    logic [WIN_W:0]           trial;
    logic                     q_bit;

    assign w_eff = (cfg.window == '0) ? WIN_W'(1) : cfg.window;
    assign w_m1  = w_eff - 1'b1;
    assign acc   = ACC_W'(avg_reg) * ACC_W'(w_m1)
                 + ACC_W'({sample_reg, {AVG_FRAC{1'b0}}});

    // restoring divide step; remainder stays below the window
    assign trial = {rem_reg, quo_reg[AVG_W-1]};
    assign q_bit = (trial >= {1'b0, w_eff});

    always_comb begin
        if (q_bit) rem_next = WIN_W'(trial - {1'b0, w_eff});
        else rem_next = trial[WIN_W-1:0];
        quo_next = {quo_reg[AVG_W-2:0], q_bit};
    end

    // decision on the captured sample and the freshly divided average (quo_reg)
    logic                     is_high, is_low, zero_sample;
    logic signed [HOLD_W-1:0] h1, h2, reload;
    logic                     do_lower, do_raise;
    logic [CAP_W-1:0]         diff_lo, diff_hi, step_lo, step_hi;
    logic [CAP_W-1:0]         cap_lowered, cap_raised;

    assign zero_sample = (sample_reg == '0);
    assign is_high = (sample_reg > cfg.high_limit)
                  || (quo_reg > {cfg.high_limit, {AVG_FRAC{1'b0}}});
    assign is_low  = (sample_reg < cfg.low_limit)
                  && (quo_reg < {cfg.low_limit, {AVG_FRAC{1'b0}}});
    assign reload  = HOLD_W'(w_eff);

    always_comb begin
        h1 = is_high ? sat_dec(hold_reg) : hold_reg;
        h2 = sat_dec(h1);
        do_lower = !zero_sample && is_high && (h1 <= 8'sd0);
        do_raise = !zero_sample && !do_lower && is_low && (h2 <= 8'sd0);
    end

    // half the distance to the bound, at least one, clamped
    always_comb begin
        diff_lo = cap_reg - cfg.fewest;
        diff_hi = cfg.most - cap_reg;
        step_lo = (diff_lo > 11'd1) ? (diff_lo >> 1) : 11'd1;
        step_hi = (diff_hi > 11'd1) ? (diff_hi >> 1) : 11'd1;
        cap_lowered = (cap_reg > cfg.fewest) ? cap_reg - step_lo : cfg.fewest;
        cap_raised  = (cap_reg < cfg.most)   ? cap_reg + step_hi : cfg.most;
    end

    always_comb begin
        hold_next = hold_reg;
        cap_next  = cap_reg;
        flag_next = flag_reg;
        act_next  = ACT_NONE;
        if (!cfg.stopped) begin
            if (do_lower) begin
                cap_next  = cap_lowered;
                flag_next = 1'b1;
                hold_next = reload;
                act_next  = ACT_LOWER;
            end else if (do_raise) begin
                cap_next  = cap_raised;
                flag_next = 1'b0;
                hold_next = reload;
                act_next  = ACT_RAISE;
            end else if (!zero_sample) begin
                hold_next = is_low ? h2 : h1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_reg  <= '0;
            hold_reg <= '0;
            cap_reg  <= RST_MOST;
            flag_reg <= 1'b1;
        end else if (cmd.commit) begin
            if (!cfg.stopped) avg_reg <= quo_reg;
            hold_reg <= hold_next;
            cap_reg  <= cap_next;
            flag_reg <= flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) sample_reg <= s_power_sample;
        if (cmd.mul) begin
            rem_reg <= acc[ACC_W-1:AVG_W];
            quo_reg <= acc[AVG_W-1:0];
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.commit) begin
            out_cap_reg  <= cap_next;
            out_flag_reg <= flag_next;
            out_act_reg  <= act_next;
            out_avg_reg  <= cfg.stopped ? avg_reg : quo_reg;
        end
    end

    assign m_cap_out     = out_cap_reg;
    assign m_throttle_on = out_flag_reg;
    assign m_action      = out_act_reg;
    assign m_average_out = out_avg_reg;

`ifndef SYNTH
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (rem_reg < w_eff))
        else $error("divider remainder out of range");
`endif

endmodule : pcthr_dpath
`default_nettype wire
